[hdl/hsl_pkg.sv]
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared types for the HSL to RGB colour conversion pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_FLAT_Q,
    SEG_FALL,
    SEG_FLAT_P
  } hsl_seg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } hsl_adv_t;

endpackage

[hdl/hsl_to_rgb.sv]
// ----------------------------------------------------------------------------
// hsl_to_rgb
// HSL to RGB colour conversion, four register stages, one colour per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in_      input      in_valid / in_stall     in_hue, in_saturation, in_lightness
// out_     output     out_valid / out_stall   out_red, out_green, out_blue
//
// out_valid rises once the accepted transaction has passed the stage one to four
// registers; one transaction is taken every cycle unless in_stall is high. Stage one
// forms l*s, stage two q, p and the hue segment, stage three the span product,
// stage four rounds and clamps.
// rst_n clears all stage valid bits. in_stall follows a stalled output only
// once every stage holds a transaction; bubbles are filled while stalled.
// ----------------------------------------------------------------------------
module hsl_to_rgb #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FRAC_BITS:0] in_hue,
  input  logic [FRAC_BITS:0] in_saturation,
  input  logic [FRAC_BITS:0] in_lightness,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAC_BITS:0] out_red,
  output logic [FRAC_BITS:0] out_green,
  output logic [FRAC_BITS:0] out_blue
);

  logic                        v1_r, v2_r, v3_r, v4_r;
  hsl_pkg::hsl_adv_t           adv;
  logic [FRAC_BITS:0]          hue_s1, light;
  logic [FRAC_BITS+1:0]        span;
  logic signed [FRAC_BITS+3:0] p_val, q_val;
  logic                        grey;

  always_comb begin
    adv.s4 = !v4_r || !out_stall;
    adv.s3 = !v3_r || adv.s4;
    adv.s2 = !v2_r || adv.s3;
    adv.s1 = !v1_r || adv.s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv.s1) v1_r <= in_valid;
      if (adv.s2) v2_r <= v1_r;
      if (adv.s3) v3_r <= v2_r;
      if (adv.s4) v4_r <= v3_r;
    end
  end

  hsl_pq #(.FRAC_BITS(FRAC_BITS)) u_pq (
    .clk        (clk),
    .adv        (adv),
    .hue        (in_hue),
    .saturation (in_saturation),
    .lightness  (in_lightness),
    .hue_s1     (hue_s1),
    .span       (span),
    .p_val      (p_val),
    .q_val      (q_val),
    .grey       (grey),
    .light      (light)
  );

  hsl_lane #(.FRAC_BITS(FRAC_BITS), .DIR(1)) u_red (
    .clk (clk), .adv (adv), .hue (hue_s1), .span (span), .p_val (p_val),
    .q_val (q_val), .grey (grey), .light (light), .chan (out_red)
  );

  hsl_lane #(.FRAC_BITS(FRAC_BITS), .DIR(0)) u_green (
    .clk (clk), .adv (adv), .hue (hue_s1), .span (span), .p_val (p_val),
    .q_val (q_val), .grey (grey), .light (light), .chan (out_green)
  );

  hsl_lane #(.FRAC_BITS(FRAC_BITS), .DIR(-1)) u_blue (
    .clk (clk), .adv (adv), .hue (hue_s1), .span (span), .p_val (p_val),
    .q_val (q_val), .grey (grey), .light (light), .chan (out_blue)
  );

  assign in_stall  = !adv.s1;
  assign out_valid = v4_r;

endmodule

[hdl/hsl_pq.sv]
// ----------------------------------------------------------------------------
// hsl_pq
// Clamps saturation and lightness, forms l*s, then q, p and the span q-p.
// Stage one holds the product, stage two the q/p results.
// ----------------------------------------------------------------------------
module hsl_pq #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  hsl_pkg::hsl_adv_t      adv,
  input  logic [FRAC_BITS:0]     hue,
  input  logic [FRAC_BITS:0]     saturation,
  input  logic [FRAC_BITS:0]     lightness,
  output logic [FRAC_BITS:0]     hue_s1,
  output logic [FRAC_BITS+1:0]   span,
  output logic signed [FRAC_BITS+3:0] p_val,
  output logic signed [FRAC_BITS+3:0] q_val,
  output logic                   grey,
  output logic [FRAC_BITS:0]     light
);

  localparam int W    = FRAC_BITS + 1;
  localparam int S    = W + 3;
  localparam int ONE  = 1 << FRAC_BITS;
  localparam int HALF = ONE >> 1;

  logic [W-1:0]     hue_r, s_r, l_r, s_c, l_c;
  logic [2*W-1:0]   prod_r, prod_nxt;
  logic             grey1_r, grey_r;
  logic [2*W:0]     ls_sum;
  logic [W-1:0]     ls;
  logic signed [S-1:0] q_nxt, p_nxt, q_r, p_r, diff;
  logic [W:0]       span_r, span_nxt;
  logic [W-1:0]     light_r;

  always_comb begin
    s_c      = (saturation > W'(ONE)) ? W'(ONE) : saturation;
    l_c      = (lightness  > W'(ONE)) ? W'(ONE) : lightness;
    prod_nxt = {{W{1'b0}}, l_c} * {{W{1'b0}}, s_c};
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      hue_r   <= hue;
      s_r     <= s_c;
      l_r     <= l_c;
      prod_r  <= prod_nxt;
      grey1_r <= (saturation == '0);
    end
  end

  always_comb begin
    ls_sum = {1'b0, prod_r} + (2*W+1)'(HALF);
    ls     = ls_sum[FRAC_BITS +: W];
    if (l_r >= W'(HALF)) begin
      q_nxt = $signed(S'(l_r)) + $signed(S'(s_r)) - $signed(S'(ls));
    end else begin
      q_nxt = $signed(S'(l_r)) + $signed(S'(ls));
    end
    p_nxt = ($signed(S'(l_r)) <<< 1) - q_nxt;
    diff  = q_nxt - p_nxt;
    span_nxt = (q_nxt > p_nxt) ? diff[W:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      q_r     <= q_nxt;
      p_r     <= p_nxt;
      span_r  <= span_nxt;
      grey_r  <= grey1_r;
      light_r <= l_r;
    end
  end

  assign hue_s1 = hue_r;
  assign span   = span_r;
  assign p_val  = p_r;
  assign q_val  = q_r;
  assign grey   = grey_r;
  assign light  = light_r;

endmodule

[hdl/hsl_lane.sv]
// ----------------------------------------------------------------------------
// hsl_lane
// One colour channel: hue offset and wrap, ramp segment, span product,
// rounding and clamp. Stages two to four of the pipeline.
// ----------------------------------------------------------------------------
module hsl_lane #(
  parameter int FRAC_BITS = 16,
  parameter int DIR       = 0
) (
  input  logic                        clk,
  input  hsl_pkg::hsl_adv_t           adv,
  input  logic [FRAC_BITS:0]          hue,
  input  logic [FRAC_BITS+1:0]        span,
  input  logic signed [FRAC_BITS+3:0] p_val,
  input  logic signed [FRAC_BITS+3:0] q_val,
  input  logic                        grey,
  input  logic [FRAC_BITS:0]          light,
  output logic [FRAC_BITS:0]          chan
);

  localparam int W    = FRAC_BITS + 1;
  localparam int S    = W + 3;
  localparam int TW   = W + 2;
  localparam int ONE  = 1 << FRAC_BITS;
  localparam int HALF = ONE >> 1;
  localparam int THIRD      = (2 * ONE + 3) / 6;
  localparam int SIXTH      = (ONE + 3) / 6;
  localparam int TWO_THIRDS = (4 * ONE + 3) / 6;

  localparam logic signed [TW-1:0] ONE_T   = TW'(ONE);
  localparam logic signed [TW-1:0] HALF_T  = TW'(HALF);
  localparam logic signed [TW-1:0] THIRD_T = TW'(THIRD);
  localparam logic signed [TW-1:0] SIXTH_T = TW'(SIXTH);
  localparam logic signed [TW-1:0] TT_T    = TW'(TWO_THIRDS);
  localparam logic signed [S-1:0]  ONE_S   = S'(ONE);

  logic signed [TW-1:0] h_ext, t_raw, t_a, t_w, x, mx;
  hsl_pkg::hsl_seg_t    seg_nxt, seg_r, seg3_r;
  logic [W:0]           m_r, m_nxt;

  logic [2*W+1:0]       prod_nxt, prod_r;
  logic signed [S-1:0]  p3_r, q3_r;
  logic                 grey3_r;
  logic [W-1:0]         l3_r;

  logic [2*W+2:0]       rnd_sum;
  logic signed [S-1:0]  ramp, val, clamped;
  logic [W-1:0]         chan_r, chan_nxt;

  always_comb begin
    h_ext = $signed({2'b00, hue});
    if (DIR > 0) begin
      t_raw = h_ext + THIRD_T;
    end else if (DIR < 0) begin
      t_raw = h_ext - THIRD_T;
    end else begin
      t_raw = h_ext;
    end
    t_a = (t_raw < 0) ? t_raw + ONE_T : t_raw;
    t_w = (t_a > ONE_T) ? t_a - ONE_T : t_a;
    if (t_w < SIXTH_T) begin
      seg_nxt = hsl_pkg::SEG_RISE;
      x       = t_w;
    end else if (t_w < HALF_T) begin
      seg_nxt = hsl_pkg::SEG_FLAT_Q;
      x       = '0;
    end else if (t_w < TT_T) begin
      seg_nxt = hsl_pkg::SEG_FALL;
      x       = TT_T - t_w;
    end else begin
      seg_nxt = hsl_pkg::SEG_FLAT_P;
      x       = '0;
    end
    mx    = (x <<< 2) + (x <<< 1);
    m_nxt = mx[W:0];
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      m_r   <= m_nxt;
      seg_r <= seg_nxt;
    end
  end

  assign prod_nxt = {{(W+1){1'b0}}, span} * {{(W+1){1'b0}}, m_r};

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      prod_r  <= prod_nxt;
      seg3_r  <= seg_r;
      p3_r    <= p_val;
      q3_r    <= q_val;
      grey3_r <= grey;
      l3_r    <= light;
    end
  end

  always_comb begin
    rnd_sum = {1'b0, prod_r} + (2*W+3)'(HALF);
    ramp    = p3_r + $signed(rnd_sum[FRAC_BITS +: S]);
    case (seg3_r)
      hsl_pkg::SEG_RISE:   val = ramp;
      hsl_pkg::SEG_FALL:   val = ramp;
      hsl_pkg::SEG_FLAT_Q: val = q3_r;
      hsl_pkg::SEG_FLAT_P: val = p3_r;
      default:             val = p3_r;
    endcase
    if (val < 0) begin
      clamped = '0;
    end else if (val > ONE_S) begin
      clamped = ONE_S;
    end else begin
      clamped = val;
    end
    chan_nxt = grey3_r ? l3_r : clamped[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

endmodule

[hdl/hsl_chk.sv]
// ----------------------------------------------------------------------------
// hsl_chk
// Port-level checks for hsl_to_rgb, bound to the top level.
// ----------------------------------------------------------------------------
module hsl_chk #(
  parameter int FRAC_BITS = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [FRAC_BITS:0] out_red,
  input logic [FRAC_BITS:0] out_green,
  input logic [FRAC_BITS:0] out_blue
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1 << FRAC_BITS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("result changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red <= ONE && out_green <= ONE && out_blue <= ONE)
    else $error("channel above full scale");

  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with output free");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("transaction did not reach output in four cycles");

endmodule

bind hsl_to_rgb hsl_chk #(.FRAC_BITS(FRAC_BITS)) u_hsl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);

[test/hsl_checker.sv]
// ----------------------------------------------------------------------------
// hsl_checker
// Watches both channels of hsl_to_rgb, predicts each colour and compares.
// Every accepted HSL transaction is converted on the spot into the RGB triple
// it must give. The triple is queued, and each accepted result is compared
// field by field against the oldest queued triple. Results that arrive with
// nothing queued count as failures.
// ----------------------------------------------------------------------------
module hsl_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [FRAC_BITS:0] in_hue,
  input  logic [FRAC_BITS:0] in_saturation,
  input  logic [FRAC_BITS:0] in_lightness,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [FRAC_BITS:0] out_red,
  input  logic [FRAC_BITS:0] out_green,
  input  logic [FRAC_BITS:0] out_blue,
  output int                 fail_count,
  output int                 colours_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE        = longint'(1) << FRAC_BITS;
  localparam longint HALF       = ONE >> 1;
  localparam longint SIXTH      = (ONE + 3) / 6;
  localparam longint THIRD      = (2 * ONE + 3) / 6;
  localparam longint TWO_THIRDS = (4 * ONE + 3) / 6;

  typedef struct packed {
    logic [FRAC_BITS:0] red;
    logic [FRAC_BITS:0] green;
    logic [FRAC_BITS:0] blue;
  } rgb_t;

  rgb_t colour_due_q[$];

  function automatic logic [FRAC_BITS:0] ramp_level(input longint p, input longint q,
                                                    input longint t_in);
    hsl_pkg::hsl_seg_t seg;
    longint   t;
    longint   span;
    longint   v;
    t = t_in;
    // wrap once only
    if (t < 0) t = t + ONE;
    if (t > ONE) t = t - ONE;
    span = (q > p) ? q - p : 0;
    if (t < SIXTH) seg = hsl_pkg::SEG_RISE;
    else if (t < HALF) seg = hsl_pkg::SEG_FLAT_Q;
    else if (t < TWO_THIRDS) seg = hsl_pkg::SEG_FALL;
    else seg = hsl_pkg::SEG_FLAT_P;
    case (seg)
      hsl_pkg::SEG_RISE:   v = p + ((span * 6 * t + HALF) >>> FRAC_BITS);
      hsl_pkg::SEG_FLAT_Q: v = q;
      hsl_pkg::SEG_FALL:   v = p + ((span * 6 * (TWO_THIRDS - t) + HALF) >>> FRAC_BITS);
      default:             v = p;
    endcase
    if (v < 0) v = 0;
    if (v > ONE) v = ONE;
    return v[FRAC_BITS:0];
  endfunction

  function automatic rgb_t hsl_predict(input logic [FRAC_BITS:0] hue,
                                       input logic [FRAC_BITS:0] sat,
                                       input logic [FRAC_BITS:0] light);
    rgb_t   c;
    longint h;
    longint s;
    longint l;
    longint ls;
    longint q;
    longint p;
    h = hue;
    s = sat;
    l = light;
    if (s > ONE) s = ONE;
    if (l > ONE) l = ONE;
    if (s == 0) begin
      c.red   = l[FRAC_BITS:0];
      c.green = l[FRAC_BITS:0];
      c.blue  = l[FRAC_BITS:0];
      return c;
    end
    ls = (l * s + HALF) >>> FRAC_BITS;
    q  = (l < HALF) ? l + ls : l + s - ls;
    p  = 2 * l - q;
    c.red   = ramp_level(p, q, h + THIRD);
    c.green = ramp_level(p, q, h);
    c.blue  = ramp_level(p, q, h - THIRD);
    return c;
  endfunction

  task automatic check_field(input string name, input logic [FRAC_BITS:0] want,
                             input logic [FRAC_BITS:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    rgb_t due;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (colour_due_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected colour, expected none, got r %0d g %0d b %0d",
                   $time, out_red, out_green, out_blue);
        end else begin
          due = colour_due_q.pop_front();
          check_field("red", due.red, out_red);
          check_field("green", due.green, out_green);
          check_field("blue", due.blue, out_blue);
        end
      end
      if (in_valid && !in_stall) begin
        colour_due_q.push_back(hsl_predict(in_hue, in_saturation, in_lightness));
      end
    end
    colours_pending <= colour_due_q.size();
  end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the hsl_to_rgb colour conversion pipeline.
// A directed set of colours hits grey, the primaries, the hue segment borders
// and out-of-range fields; random colours then run through phases of sender
// gaps and receiver stalls, including one long receiver hold-off that fills
// the pipeline. Checking is done by hsl_checker alongside the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB          = 16;
  localparam int ONE         = 1 << FB;
  localparam int HALF        = ONE / 2;
  localparam int SIXTH       = (ONE + 3) / 6;
  localparam int THIRD       = (2 * ONE + 3) / 6;
  localparam int TWO_THIRDS  = (4 * ONE + 3) / 6;
  localparam int FIELD_MAX   = 2 * ONE - 1;
  localparam int PHASE_ITEMS = 355;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [FB:0]   in_hue;
  logic [FB:0]   in_saturation;
  logic [FB:0]   in_lightness;
  logic          out_valid;
  logic          out_stall;
  logic [FB:0]   out_red;
  logic [FB:0]   out_green;
  logic [FB:0]   out_blue;

  int fail_count;
  int colours_pending;
  int send_idle  = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  bit hold_start = 1'b0;
  bit hold_done  = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hsl_to_rgb #(.FRAC_BITS(FB)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_lightness (in_lightness),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  hsl_checker #(.FRAC_BITS(FB)) colour_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_hue         (in_hue),
    .in_saturation  (in_saturation),
    .in_lightness   (in_lightness),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .fail_count     (fail_count),
    .colours_pending(colours_pending)
  );

  function automatic logic [FB:0] rand_level();
    case ($urandom_range(15))
      0:       return '0;
      1:       return ONE[FB:0];
      2, 3:    return 17'($urandom_range(FIELD_MAX));
      4:       return 17'(HALF - 2 + int'($urandom_range(4)));
      default: return 17'($urandom_range(ONE));
    endcase
  endfunction

  function automatic logic [FB:0] rand_hue();
    int border;
    int v;
    case ($urandom_range(4))
      0: border = 0;
      1: border = SIXTH;
      2: border = HALF;
      3: border = TWO_THIRDS;
      default: border = ONE;
    endcase
    case ($urandom_range(7))
      0:       return 17'($urandom_range(FIELD_MAX));
      1, 2, 3: begin
        // land one of the three channels on a segment border
        v = border + (int'($urandom_range(2)) - 1) * THIRD + int'($urandom_range(4)) - 2;
        if (v < 0) v = v + ONE;
        return 17'(v);
      end
      default: return 17'($urandom_range(ONE));
    endcase
  endfunction

  task automatic send_colour(input logic [FB:0] h, input logic [FB:0] s,
                             input logic [FB:0] l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_lightness  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_levels(input int h, input int s, input int l);
    send_colour(17'(h), 17'(s), 17'(l));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (colours_pending != 0) @(posedge clk);
  endtask

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_lightness  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_levels(0, 0, 0);
    send_levels(0, 0, ONE);
    send_levels(12345, 0, 40000);
    send_levels(0, 0, FIELD_MAX);
    send_levels(0, ONE, HALF);
    send_levels(THIRD, ONE, HALF);
    send_levels(TWO_THIRDS, ONE, HALF);
    send_levels(ONE, ONE, HALF);
    send_levels(SIXTH, ONE, HALF);
    send_levels(SIXTH - 1, 65535, 1);
    send_levels(HALF, 40000, 20000);
    send_levels(TWO_THIRDS, 30000, HALF);
    send_levels(TWO_THIRDS - 1, 50000, 50000);
    send_levels(43690, ONE, HALF - 1);
    send_levels(FIELD_MAX, FIELD_MAX, FIELD_MAX);
    send_levels(70000, 20000, 30000);
    send_levels(100000, 30000, 98000);
    send_levels(5000, 90000, 10000);
    send_levels(1, 1, 1);
    send_levels(65535, 65535, 65535);

    // pause the sender until every colour is back
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 72; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 72; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_colour(rand_hue(), rand_level(), rand_level());
      end
      if (ph == 0) begin
        // hold the receiver off while the sender keeps offering
        hold_start = 1'b1;
        while (!hold_done) send_colour(rand_hue(), rand_level(), rand_level());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
